// ===== design/u2a_pkg.sv =====
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared types, constants and helpers for the unsigned to ASCII radix unit.
// ----------------------------------------------------------------------------
package u2a_pkg;

    // Digit store limits.
    localparam int MAX_DIGITS_DEF = 16;
    localparam int RESULT_LIMIT   = 16;

    // Field widths.
    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int TOTAL_W = 32;

    // Conversion modes.
    localparam logic [FUNC_W-1:0] MODE_DEC     = 2'd0;
    localparam logic [FUNC_W-1:0] MODE_LHEX    = 2'd1;
    localparam logic [FUNC_W-1:0] MODE_UHEX    = 2'd2;
    localparam logic [FUNC_W-1:0] MODE_LHEX64  = 2'd3;

    // floor(v * RECIP10 / 2^35) equals v / 10 for every 32-bit v.
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new request
        logic gen;    // produce one digit into the store
        logic emit;   // stream digits out of the store
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gen_done;   // the digit produced this cycle is the final one
        logic emit_done;  // the final digit moved into the output register
    } t_status;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
        if (d < 4'd10)
            return ASCII_ZERO + {4'b0000, d};
        else
            return base + {4'b0000, d - 4'd10};
    endfunction

endpackage

// ===== design/u2a_ctrl.sv =====
// ----------------------------------------------------------------------------
// u2a_ctrl
// Controller state machine: accept, digit generation and digit streaming.
// ----------------------------------------------------------------------------
module u2a_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  u2a_pkg::t_status i_status,
    output u2a_pkg::t_cmd    o_cmd
);
    import u2a_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GEN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_GEN;
                end
            end
            ST_GEN: begin
                o_cmd.gen = 1'b1;
                if (i_status.gen_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.emit_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_req_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/u2a_dpath.sv =====
// ----------------------------------------------------------------------------
// u2a_dpath
// Datapath: digit extraction, digit store, character counter, output register.
// ----------------------------------------------------------------------------
module u2a_dpath #(
    parameter int MAX_DIGITS = u2a_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  u2a_pkg::t_cmd                 i_cmd,
    output u2a_pkg::t_status              o_status,
    input  logic [u2a_pkg::FUNC_W-1:0]    i_func,
    input  logic [u2a_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [u2a_pkg::CHAR_W-1:0]    o_char,
    output logic                          o_last,
    output logic [u2a_pkg::TOTAL_W-1:0]   o_total
);
    import u2a_pkg::*;

    localparam int DEPTH = (MAX_DIGITS > RESULT_LIMIT) ? RESULT_LIMIT : MAX_DIGITS;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Digit store.
    logic [3:0] r_mem [DEPTH];

    // Conversion registers.
    logic [VALUE_W-1:0] r_val;
    logic [63:0]        r_prod;
    logic               r_dec;
    logic               r_upper;
    logic [CNT_W-1:0]   r_wcnt;

    // Read side.
    logic [IDX_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_rd_left;
    logic [3:0]         r_rd_data;
    logic               r_rd_last;
    logic               r_rd_vld;

    // Output side.
    logic               r_out_vld;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;
    logic [TOTAL_W-1:0] r_out_cnt;
    logic [TOTAL_W-1:0] r_count;
    logic [TOTAL_W-1:0] n_count;

    logic [VALUE_W-1:0] q_next;
    logic [VALUE_W-1:0] load_val;
    logic [3:0]         q10_lo;
    logic [3:0]         digit;
    logic [31:0]        mul_in;
    logic [63:0]        mul_prod;
    logic               gen_done;
    logic               load_out;
    logic               issue;

    // Quotient in decimal mode sits in the upper bits of the registered product.
    assign q10_lo = {r_prod[RECIP10_SHIFT], 3'b000} + {r_prod[RECIP10_SHIFT+2:RECIP10_SHIFT], 1'b0};
    assign q_next = r_dec ? {{RECIP10_SHIFT{1'b0}}, r_prod[63:RECIP10_SHIFT]}
                          : {4'b0000, r_val[VALUE_W-1:4]};
    assign digit  = r_dec ? (r_val[3:0] - q10_lo) : r_val[3:0];

    assign load_val = (i_func == MODE_LHEX64) ? i_value : {32'b0, i_value[31:0]};
    assign mul_in   = i_cmd.load ? i_value[31:0] : q_next[31:0];
    assign mul_prod = {32'b0, mul_in} * {32'b0, RECIP10};

    assign gen_done = (q_next == '0) || (r_wcnt == CNT_W'(DEPTH - 1));

    assign load_out = r_rd_vld && (!r_out_vld || i_out_ready);
    assign issue    = i_cmd.emit && (r_rd_left != '0) && (!r_rd_vld || load_out);
    assign n_count  = (r_count == '1) ? r_count : r_count + TOTAL_W'(1);

    assign o_status.gen_done  = i_cmd.gen && gen_done;
    assign o_status.emit_done = load_out && r_rd_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val   <= load_val;
            r_prod  <= mul_prod;
            r_dec   <= (i_func == MODE_DEC);
            r_upper <= (i_func == MODE_UHEX);
        end else if (i_cmd.gen) begin
            r_mem[r_wcnt[IDX_W-1:0]] <= digit;
            r_val  <= q_next;
            r_prod <= mul_prod;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_rd_ptr];
            r_rd_last <= (r_rd_left == CNT_W'(1));
        end
        if (load_out) begin
            r_out_char <= digit_to_ascii(r_rd_data, r_upper);
            r_out_last <= r_rd_last;
            r_out_cnt  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt    <= '0;
            r_rd_ptr  <= '0;
            r_rd_left <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_count   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_wcnt <= '0;
            end else if (i_cmd.gen) begin
                r_wcnt <= r_wcnt + CNT_W'(1);
                if (gen_done) begin
                    r_rd_ptr  <= r_wcnt[IDX_W-1:0];
                    r_rd_left <= r_wcnt + CNT_W'(1);
                end
            end else if (issue) begin
                r_rd_ptr  <= r_rd_ptr - IDX_W'(1);
                r_rd_left <= r_rd_left - CNT_W'(1);
            end

            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (load_out) begin
                r_rd_vld <= 1'b0;
            end

            if (load_out) begin
                r_out_vld <= 1'b1;
                r_count   <= n_count;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_char      = r_out_char;
    assign o_last      = r_out_last;
    assign o_total     = r_out_cnt;

endmodule

// ===== design/unsigned_to_ascii_radix_unit.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_unit
// Converts an unsigned number to its ASCII decimal or hex digits, MSB first.
// ----------------------------------------------------------------------------
// Sequence: each request passes through capture, generation of its n digits
//   (n is 1 to MAX_DIGITS, at most 16), one read stage, then streaming at one
//   character a cycle while the sink accepts. A new request is taken once the
//   last character has entered the output register.
// Reset: synchronous, active low; clears the controller, the valid flags and
//   the running character count. The digit store is not cleared.
module unsigned_to_ascii_radix_unit #(
    parameter int MAX_DIGITS = u2a_pkg::MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request side.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    // Character side.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] character, [39:8] total_count
    output logic        m_axis_tlast    // last digit of the number
);
    import u2a_pkg::*;

    t_cmd               cmd;
    t_status            status;
    logic [CHAR_W-1:0]  out_char;
    logic [TOTAL_W-1:0] out_total;

    // The controller sequences each request through three phases: capture,
    // digit generation (least significant digit first, into the digit store)
    // and streaming (store read back in reverse order). A request is taken
    // only in the idle phase, but the last character of the previous number
    // may still sit in the output register waiting for the sink.
    u2a_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the working value, the reciprocal multiplier used for
    // the decimal divide by ten, the digit store, a one-entry read stage and
    // the output register with the saturating character counter.
    u2a_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_func      (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_char      (out_char),
        .o_last      (m_axis_tlast),
        .o_total     (out_total)
    );

    // Character in the low byte, running count above it.
    assign m_axis_tdata = {out_total, out_char};

endmodule

// ===== design/u2a_monitor.sv =====
// ----------------------------------------------------------------------------
// u2a_monitor
// Port-level checks for the unsigned to ASCII radix unit.
// ----------------------------------------------------------------------------
module u2a_monitor (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    logic        s_acc;
    logic        m_acc;
    logic        r_busy;
    logic        r_seen;
    logic [31:0] r_prev;
    logic [7:0]  ch;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    assign ch    = m_axis_tdata[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seen <= 1'b0;
            r_prev <= '0;
        end else begin
            if (s_acc) begin
                r_busy <= 1'b1;
            end else if (m_acc && m_axis_tlast) begin
                r_busy <= 1'b0;
            end
            if (m_acc) begin
                r_seen <= 1'b1;
                r_prev <= m_axis_tdata[39:8];
            end
        end
    end

    // A stalled character holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // The running count steps by one per character and sticks at its maximum.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_acc && r_seen |->
            (r_prev == 32'hFFFF_FFFF) ? (m_axis_tdata[39:8] == 32'hFFFF_FFFF)
                                      : (m_axis_tdata[39:8] == r_prev + 32'd1))
        else $error("character count out of sequence");

    // A new number is taken only once the previous one has reached its last digit.
    a_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |-> !r_busy || (m_axis_tvalid && m_axis_tlast))
        else $error("request accepted while a number is still being converted");

    // Every character is a decimal or hex digit.
    a_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h66) ||
            (ch >= 8'h41 && ch <= 8'h46))
        else $error("output character is not a digit");

endmodule

bind unsigned_to_ascii_radix_unit u2a_monitor u_u2a_monitor (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
